// ----- rtl/mts_pkg.sv -----
// Package for the multi-timer scheduler: shared types, codes and defaults.
// Used by mts_ctrl, mts_dp and multi_timer_scheduler_unit; no dependencies.
`default_nettype none
package mts_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 48;
    localparam int ID_BITS_DEF    = 16;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SCHED  = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result event kinds
    typedef enum logic [2:0] {
        EV_TICK_IDLE = 3'd0,
        EV_FIRED     = 3'd1,
        EV_SCHEDULED = 3'd2,
        EV_FULL      = 3'd3,
        EV_CANCELLED = 3'd4,
        EV_NOT_FOUND = 3'd5,
        EV_CLEARED   = 3'd6
    } t_event;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] delay_ticks;
        logic [31:0] interval_ticks;
        logic [31:0] payload_tag;
        logic [15:0] cancel_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] timer_ident;
        logic [31:0] tag_out;
        logic        rearmed;
        logic [4:0]  timers_active;
        logic        last;
    } t_result;

    // Kind of slot scan the datapath runs
    typedef enum logic [1:0] {
        SC_FREE,
        SC_FIND,
        SC_MARK,
        SC_SEL
    } t_scan;

    typedef struct packed {
        logic  accept;
        logic  scan_start;
        t_scan scan_kind;
        logic  do_sched;
        logic  do_cancel;
        logic  do_quiet;
        logic  do_read;
        logic  do_fire;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic due_any;
        logic last_due;
    } t_dp_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_FIND,
        S_MARK,
        S_CHECK,
        S_SEL,
        S_SCHED,
        S_CANCEL,
        S_READ,
        S_FIRE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/mts_ctrl.sv -----
// Controller state machine of the multi-timer scheduler.
// Depends on mts_pkg; drives mts_dp through command and status structs.
`default_nettype none
module mts_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [1:0]          i_op,
    input  wire mts_pkg::t_dp_status i_status,
    output mts_pkg::t_dp_cmd         o_cmd,
    output logic                     o_busy
);
    import mts_pkg::*;

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence scans and actions
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.scan_kind = SC_FREE;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_op)
                        OP_TICK: begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_kind  = SC_MARK;
                            n_state = S_MARK;
                        end
                        OP_SCHED: begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_kind  = SC_FREE;
                            n_state = S_FREE;
                        end
                        OP_CANCEL: begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_kind  = SC_FIND;
                            n_state = S_FIND;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FREE:   if (i_status.scan_done) n_state = S_SCHED;
            S_FIND:   if (i_status.scan_done) n_state = S_CANCEL;
            S_MARK:   if (i_status.scan_done) n_state = S_CHECK;
            S_SEL:    if (i_status.scan_done) n_state = S_READ;
            S_SCHED: begin
                o_cmd.do_sched = 1'b1;
                n_state = S_IDLE;
            end
            S_CANCEL: begin
                o_cmd.do_cancel = 1'b1;
                n_state = S_IDLE;
            end
            S_CHECK: begin
                if (i_status.due_any) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_kind  = SC_SEL;
                    n_state = S_SEL;
                end else begin
                    o_cmd.do_quiet = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.do_read = 1'b1;
                n_state = S_FIRE;
            end
            S_FIRE: begin
                o_cmd.do_fire = 1'b1;
                if (i_status.last_due) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_kind  = SC_SEL;
                    n_state = S_SEL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/mts_dp.sv -----
// Datapath of the multi-timer scheduler: slot memories, scan unit, results.
// Depends on mts_pkg; commanded by mts_ctrl.
`default_nettype none
module mts_dp #(
    parameter int NUM_TIMERS = mts_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = mts_pkg::TIME_BITS_DEF,
    parameter int ID_BITS    = mts_pkg::ID_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mts_pkg::t_in        i_item,
    input  wire mts_pkg::t_dp_cmd    i_cmd,
    output mts_pkg::t_dp_status      o_status,
    output logic                     o_strobe,
    output mts_pkg::t_result         o_result
);
    import mts_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int MW = (ID_BITS > 16) ? ID_BITS : 16;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

    // Slot memories
    logic [TIME_BITS-1:0] m_fire  [NUM_TIMERS];
    logic [31:0]          m_intv  [NUM_TIMERS];
    logic [ID_BITS-1:0]   m_ident [NUM_TIMERS];
    logic [31:0]          m_tag   [NUM_TIMERS];

    logic [TIME_BITS-1:0] r_rd_fire;
    logic [31:0]          r_rd_intv;
    logic [ID_BITS-1:0]   r_rd_ident;
    logic [31:0]          r_rd_tag;

    logic [TIME_BITS-1:0] r_time;
    logic [ID_BITS-1:0]   r_next_id;
    logic [NUM_TIMERS-1:0] r_valid;
    logic [NUM_TIMERS-1:0] r_due;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_due_cnt;
    t_in                  r_in;
    t_scan                r_kind;
    logic [IW-1:0]        r_idx;
    logic                 r_issue;
    logic                 r_p_v;
    logic [IW-1:0]        r_p_idx;
    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    logic [TIME_BITS-1:0] r_best_d;
    logic                 r_strobe;
    t_result              r_out;

    logic [IW-1:0]        rd_addr;
    logic [TIME_BITS-1:0] late;
    logic                 p_valid;
    logic                 p_due;
    logic                 take;
    logic                 per;

    assign rd_addr = i_cmd.do_read ? r_hit_idx : r_idx;
    assign late    = r_time - r_rd_fire;
    assign p_valid = r_valid[r_p_idx];
    assign p_due   = p_valid && !late[TIME_BITS-1];
    assign per     = (r_rd_intv != 32'd0);

    // Decide whether the slot in the evaluate stage wins this scan
    always_comb begin
        take = 1'b0;
        unique case (r_kind)
            SC_FREE: take = !r_hit && !p_valid;
            SC_FIND: take = !r_hit && p_valid &&
                            (MW'(r_rd_ident) == MW'(r_in.cancel_id));
            SC_MARK: take = 1'b0;
            SC_SEL:  take = r_due[r_p_idx] && (!r_hit || (late > r_best_d));
            default: take = 1'b0;
        endcase
    end

    assign o_status.scan_done = r_p_v && (r_p_idx == LAST_IDX);
    assign o_status.hit       = r_hit;
    assign o_status.due_any   = (r_due_cnt != '0);
    assign o_status.last_due  = (r_due_cnt == CW'(1));

    // Read and write slot memories
    always_ff @(posedge i_clk) begin
        r_rd_fire  <= m_fire[rd_addr];
        r_rd_intv  <= m_intv[rd_addr];
        r_rd_ident <= m_ident[rd_addr];
        r_rd_tag   <= m_tag[rd_addr];
        if (i_cmd.do_sched && r_hit) begin
            m_fire[r_hit_idx]  <= r_time + TIME_BITS'(r_in.delay_ticks);
            m_intv[r_hit_idx]  <= r_in.interval_ticks;
            m_ident[r_hit_idx] <= r_next_id;
            m_tag[r_hit_idx]   <= r_in.payload_tag;
        end else if (i_cmd.do_fire && per) begin
            m_fire[r_hit_idx] <= r_rd_fire + TIME_BITS'(r_rd_intv);
        end
    end

    // Latch the transaction and track the scan winner
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_item;
        end
        r_p_idx <= r_idx;
        if (i_cmd.scan_start) begin
            r_kind <= i_cmd.scan_kind;
            r_hit  <= 1'b0;
        end else if (r_p_v && take) begin
            r_hit     <= 1'b1;
            r_hit_idx <= r_p_idx;
            r_best_d  <= late;
        end
    end

    // Control state: time, ids, valid and due bits, scan counter, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_next_id <= '0;
            r_valid   <= '0;
            r_due     <= '0;
            r_count   <= '0;
            r_due_cnt <= '0;
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_p_v     <= 1'b0;
            r_strobe  <= 1'b0;
            r_out     <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_p_v    <= r_issue;
            // advance the scan address
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_issue <= 1'b1;
                if (i_cmd.scan_kind == SC_MARK) begin
                    r_due_cnt <= '0;
                end
            end else if (r_issue) begin
                if (r_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            // mark due slots
            if (r_p_v && (r_kind == SC_MARK)) begin
                r_due[r_p_idx] <= p_due;
                if (p_due) begin
                    r_due_cnt <= r_due_cnt + 1'b1;
                end
            end
            if (i_cmd.accept) begin
                if (i_item.operation == OP_TICK) begin
                    r_time <= r_time + 1'b1;
                end else if (i_item.operation == OP_CLEAR) begin
                    r_valid  <= '0;
                    r_count  <= '0;
                    r_strobe <= 1'b1;
                    r_out    <= '{EV_CLEARED, 16'd0, 32'd0, 1'b0, 5'd0, 1'b1};
                end
            end
            if (i_cmd.do_sched) begin
                r_strobe <= 1'b1;
                if (r_hit) begin
                    r_valid[r_hit_idx] <= 1'b1;
                    r_count   <= r_count + 1'b1;
                    r_next_id <= r_next_id + 1'b1;
                    r_out <= '{EV_SCHEDULED, 16'(r_next_id), 32'd0, 1'b0,
                               5'(r_count + 1'b1), 1'b1};
                end else begin
                    r_out <= '{EV_FULL, 16'd0, 32'd0, 1'b0, 5'(r_count), 1'b1};
                end
            end
            if (i_cmd.do_cancel) begin
                r_strobe <= 1'b1;
                if (r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_count <= r_count - 1'b1;
                    r_out <= '{EV_CANCELLED, r_in.cancel_id, 32'd0, 1'b0,
                               5'(r_count - 1'b1), 1'b1};
                end else begin
                    r_out <= '{EV_NOT_FOUND, 16'd0, 32'd0, 1'b0, 5'(r_count), 1'b1};
                end
            end
            if (i_cmd.do_quiet) begin
                r_strobe <= 1'b1;
                r_out    <= '{EV_TICK_IDLE, 16'd0, 32'd0, 1'b0, 5'(r_count), 1'b1};
            end
            // fire the selected slot: reload or drop it
            if (i_cmd.do_fire) begin
                r_strobe <= 1'b1;
                r_due[r_hit_idx] <= 1'b0;
                r_due_cnt <= r_due_cnt - 1'b1;
                if (per) begin
                    r_out <= '{EV_FIRED, 16'(r_rd_ident), r_rd_tag, 1'b1,
                               5'(r_count), (r_due_cnt == CW'(1))};
                end else begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_count <= r_count - 1'b1;
                    r_out <= '{EV_FIRED, 16'(r_rd_ident), r_rd_tag, 1'b0,
                               5'(r_count - 1'b1), (r_due_cnt == CW'(1))};
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ----- rtl/multi_timer_scheduler_unit.sv -----
// Top level of the multi-timer scheduler: controller plus datapath.
// Depends on mts_pkg, mts_ctrl and mts_dp.
//
// Usage: drive i_item and raise i_start; the transaction is taken at the
// clock edge where i_start is high and o_busy is low. Results appear on
// o_result, each marked by o_strobe for one cycle; the receiver cannot stall
// them, and the field last marks the final result of a transaction.
// A clear answers in the cycle after it is taken.
// Schedule and cancel scan every slot through the slot memory read port,
// one slot a cycle, and then answer. A tick scans once to mark due slots,
// then runs one selection scan per firing; a tick with no firing answers
// once the marking scan is done.
// o_busy drops in the cycle the last result is shown, so a new transaction
// can be taken while that result is on the ports.
// Reset (synchronous, active low) zeroes time and the id counter and frees
// every slot; slot contents stay undefined until scheduled.
`default_nettype none
module multi_timer_scheduler_unit #(
    parameter int NUM_TIMERS = mts_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = mts_pkg::TIME_BITS_DEF,
    parameter int ID_BITS    = mts_pkg::ID_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire mts_pkg::t_in     i_item,
    output logic                  o_busy,
    output logic                  o_strobe,
    output mts_pkg::t_result      o_result
);
    import mts_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence each transaction
    mts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_op     (i_item.operation),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // Hold slots and produce results
    mts_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ----- bench/multi_timer_scheduler_unit_tb.sv -----
// Testbench for multi_timer_scheduler_unit: random and directed timer commands,
// results checked against a behavioral timer-table model. Depends on mts_pkg.
`timescale 1ns / 1ps
module multi_timer_scheduler_unit_tb;
    import mts_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [47:0] HALF_SPAN = 48'h8000_0000_0000;

    // Timer table model and queue of expected results
    class timer_board;
        logic [47:0] now_ticks;
        logic [15:0] id_counter;
        bit          live[SLOTS];
        logic [47:0] due_at[SLOTS];
        logic [31:0] period[SLOTS];
        logic [15:0] ident[SLOTS];
        logic [31:0] tag[SLOTS];
        t_result     pending[$];
        int          errors;

        function new();
            now_ticks = '0;
            id_counter = '0;
            errors = 0;
            foreach (live[i]) live[i] = 0;
        endfunction

        function logic [4:0] live_count();
            int n;
            n = 0;
            foreach (live[i]) if (live[i]) n++;
            return n[4:0];
        endfunction

        function void push(t_event kind, logic [15:0] id, logic [31:0] tg,
                           bit per, bit fin);
            t_result r;
            r.event_kind = kind;
            r.timer_ident = id;
            r.tag_out = tg;
            r.rearmed = per;
            r.timers_active = live_count();
            r.last = fin;
            pending.push_back(r);
        endfunction

        // Apply one accepted transaction and queue its results
        function void note_command(t_in c);
            int slot, nd, best, s;
            int order[$];
            logic [47:0] late[$];
            logic [47:0] d;
            bit per;
            slot = -1;
            case (c.operation)
                OP_SCHED: begin
                    foreach (live[i]) if (!live[i] && slot < 0) slot = i;
                    if (slot < 0) begin
                        push(EV_FULL, '0, '0, 0, 1);
                    end else begin
                        live[slot] = 1;
                        due_at[slot] = now_ticks + c.delay_ticks;
                        period[slot] = c.interval_ticks;
                        tag[slot] = c.payload_tag;
                        ident[slot] = id_counter;
                        id_counter++;
                        push(EV_SCHEDULED, ident[slot], '0, 0, 1);
                    end
                end
                OP_CANCEL: begin
                    foreach (live[i])
                        if (slot < 0 && live[i] && ident[i] == c.cancel_id) slot = i;
                    if (slot < 0) begin
                        push(EV_NOT_FOUND, '0, '0, 0, 1);
                    end else begin
                        live[slot] = 0;
                        push(EV_CANCELLED, c.cancel_id, '0, 0, 1);
                    end
                end
                OP_CLEAR: begin
                    foreach (live[i]) live[i] = 0;
                    push(EV_CLEARED, '0, '0, 0, 1);
                end
                default: begin
                    now_ticks++;
                    foreach (live[i]) begin
                        d = now_ticks - due_at[i];
                        if (live[i] && d < HALF_SPAN) begin
                            order.push_back(i);
                            late.push_back(d);
                        end
                    end
                    nd = order.size();
                    if (nd == 0) push(EV_TICK_IDLE, '0, '0, 0, 1);
                    // Fire most overdue first, ties to the lower slot
                    for (int k = 0; k < nd; k++) begin
                        best = 0;
                        for (int j = 1; j < order.size(); j++)
                            if (late[j] > late[best]) best = j;
                        s = order[best];
                        order.delete(best);
                        late.delete(best);
                        per = period[s] != 0;
                        if (per) due_at[s] = due_at[s] + period[s];
                        else live[s] = 0;
                        push(EV_FIRED, ident[s], tag[s], per, k == nd - 1);
                    end
                end
            endcase
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.event_kind !== want.event_kind)
                $display("%0t: event_kind exp %0d got %0d", $time,
                         want.event_kind, got.event_kind);
            if (got.timer_ident !== want.timer_ident)
                $display("%0t: timer_ident exp %h got %h", $time,
                         want.timer_ident, got.timer_ident);
            if (got.tag_out !== want.tag_out)
                $display("%0t: tag_out exp %h got %h", $time, want.tag_out, got.tag_out);
            if (got.rearmed !== want.rearmed)
                $display("%0t: rearmed exp %b got %b", $time,
                         want.rearmed, got.rearmed);
            if (got.timers_active !== want.timers_active)
                $display("%0t: timers_active exp %0d got %0d", $time,
                         want.timers_active, got.timers_active);
            if (got.last !== want.last)
                $display("%0t: last exp %b got %b", $time, want.last, got.last);
            if (got !== want) errors++;
        endfunction
    endclass

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    i_start = 0;
    t_in     i_item = '0;
    logic    o_busy, o_strobe;
    t_result o_result;
    timer_board board = new();
    bit      calm = 0;

    multi_timer_scheduler_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Check every strobed result at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && o_strobe) board.check_result(o_result);

    // Present one transaction and hold it until taken
    task automatic send_command(t_in c);
        while (!calm && $urandom_range(99) < 34) begin
            i_start <= 0;
            @(negedge i_clk);
        end
        i_item <= c;
        i_start <= 1;
        do @(posedge i_clk); while (o_busy);
        board.note_command(c);
        @(negedge i_clk);
    endtask

    task automatic do_tick();
        t_in c;
        c = '0;
        c.operation = OP_TICK;
        send_command(c);
    endtask

    task automatic do_schedule(logic [31:0] dly, logic [31:0] per, logic [31:0] tg);
        t_in c;
        c = '0;
        c.operation = OP_SCHED;
        c.delay_ticks = dly;
        c.interval_ticks = per;
        c.payload_tag = tg;
        send_command(c);
    endtask

    task automatic do_cancel(logic [15:0] id);
        t_in c;
        c = '0;
        c.operation = OP_CANCEL;
        c.cancel_id = id;
        send_command(c);
    endtask

    task automatic do_clear();
        t_in c;
        c = '0;
        c.operation = OP_CLEAR;
        send_command(c);
    endtask

    // Random command with noise in unused fields
    task automatic random_command();
        t_in c;
        int pick;
        c.operation = OP_TICK;
        c.delay_ticks = $urandom;
        c.interval_ticks = $urandom;
        c.payload_tag = $urandom;
        c.cancel_id = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            c.operation = OP_TICK;
        end else if (pick < 80) begin
            c.operation = OP_SCHED;
            if ($urandom_range(9) < 8) c.delay_ticks = $urandom_range(6);
            if ($urandom_range(9) < 7) c.interval_ticks = $urandom_range(5);
        end else if (pick < 95) begin
            c.operation = OP_CANCEL;
            if ($urandom_range(3) != 0)
                c.cancel_id = board.id_counter - 16'($urandom_range(20));
        end else begin
            c.operation = OP_CLEAR;
        end
        send_command(c);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, all operations, full table, zero delay
        do_tick();
        do_cancel(16'hFFFF);
        do_schedule(0, 0, 32'hFFFF_FFFF);
        do_schedule(0, 32'hFFFF_FFFF, 32'h0);
        do_schedule(32'hFFFF_FFFF, 0, 32'hA5A5_5A5A);
        do_tick();
        do_cancel(16'd1);
        do_cancel(16'd1);
        do_clear();
        for (int i = 0; i < 17; i++) do_schedule(i % 3, i % 2, 32'h100 + i);
        do_tick();

        // Drain everything before going on
        i_start <= 0;
        @(negedge i_clk);
        while (board.pending.size() != 0) @(negedge i_clk);
        do_clear();

        // Random part, first stretch without idling
        calm = 1;
        for (int n = 0; n < 210; n++) begin
            if (n == 40) calm = 0;
            random_command();
        end

        i_start <= 0;
        @(negedge i_clk);
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("multi_timer_scheduler_unit regression: pass");
        else
            $display("multi_timer_scheduler_unit regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("multi_timer_scheduler_unit regression: fail");
        $finish;
    end
endmodule
